@@ sv/occupancy_grid_fusion_assert.svh @@
// assertion macros for the occupancy grid fusion block
`ifndef OCCUPANCY_GRID_FUSION_ASSERT_SVH
`define OCCUPANCY_GRID_FUSION_ASSERT_SVH
`ifndef SYNTH
`define OGF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define OGF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define OGF_ASSERT_IMPL(lbl, ante, cons)
`define OGF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/ogf_pkg.sv @@
package ogf_pkg;

  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;

  localparam logic [2:0] REG_GLOBAL_MIN_X    = 3'd0;
  localparam logic [2:0] REG_GLOBAL_MIN_Y    = 3'd1;
  localparam logic [2:0] REG_GLOBAL_INV_CELL = 3'd2;
  localparam logic [2:0] REG_LOCAL_ORIGIN_X  = 3'd3;
  localparam logic [2:0] REG_LOCAL_ORIGIN_Y  = 3'd4;
  localparam logic [2:0] REG_LOCAL_CELL_SIZE = 3'd5;

  localparam logic        CMD_FUSE = 1'b0;
  localparam logic        CMD_READ = 1'b1;
  localparam logic signed [7:0] VAL_OBSTACLE = -8'sd1;

  localparam logic [31:0] INV_CELL_RST  = 32'd65536;
  localparam logic [31:0] CELL_SIZE_RST = 32'd6554;

  typedef struct packed {
    logic vld;
    logic rd;
    logic wr;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] global_min_x;
    logic signed [31:0] global_min_y;
    logic        [31:0] global_inv_cell;
    logic signed [31:0] local_origin_x;
    logic signed [31:0] local_origin_y;
    logic        [31:0] local_cell_size;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/ogf_xform.sv @@
module ogf_xform (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ogf_pkg::cfg_t        cfg,
  input  logic                 in_take,
  input  logic                 in_command,
  input  logic signed [7:0]    in_cell_value,
  input  logic [7:0]           in_cell_col,
  input  logic [7:0]           in_cell_row,
  input  logic signed [15:0]   in_quat_w,
  input  logic signed [15:0]   in_quat_x,
  input  logic signed [15:0]   in_quat_y,
  input  logic signed [15:0]   in_quat_z,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  output ogf_pkg::ctl_t        ctl_o,
  output logic signed [7:0]    val_o,
  output logic [7:0]           col_o,
  output logic [7:0]           row_o,
  output logic signed [64:0]   bpx_o,
  output logic signed [64:0]   bpy_o
);

  ogf_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  logic signed [7:0] val1_r, val2_r, val3_r, val4_r, val5_r, val6_r, val7_r;
  logic [7:0] col1_r, col2_r, col3_r, col4_r, col5_r, col6_r, col7_r;
  logic [7:0] row1_r, row2_r, row3_r, row4_r, row5_r, row6_r, row7_r;
  logic signed [15:0] qw1_r, qx1_r, qy1_r, qz1_r;
  logic signed [31:0] px1_r, px2_r, px3_r, px4_r, py1_r, py2_r, py3_r, py4_r;
  logic [40:0] pcx2_r, pcy2_r;
  logic signed [31:0] ww2_r, xx2_r, yy2_r, zz2_r, xy2_r, wz2_r;
  logic signed [31:0] vx3_r, vy3_r;
  logic signed [33:0] m00_3_r, m01_3_r, m10_3_r, m11_3_r;
  logic signed [65:0] p00_4_r, p01_4_r, p10_4_r, p11_4_r;
  logic signed [31:0] ex5_r, ey5_r, dx6_r, dy6_r;
  logic signed [64:0] bpx7_r, bpy7_r;
  ogf_pkg::ctl_t ctl1_nxt;
  logic signed [36:0] rx_nxt, ry_nxt;

  always_comb begin
    ctl1_nxt.vld = in_take;
    ctl1_nxt.rd  = in_command == ogf_pkg::CMD_READ;
    ctl1_nxt.wr  = (in_command == ogf_pkg::CMD_FUSE) &&
                   ((in_cell_value == ogf_pkg::VAL_OBSTACLE) || (in_cell_value > 8'sd0));
    rx_nxt = 37'($signed(p00_4_r[65:30])) + 37'($signed(p01_4_r[65:30]));
    ry_nxt = 37'($signed(p10_4_r[65:30])) + 37'($signed(p11_4_r[65:30]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0; ctl2_r <= '0; ctl3_r <= '0; ctl4_r <= '0;
      ctl5_r <= '0; ctl6_r <= '0; ctl7_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt; ctl2_r <= ctl1_r; ctl3_r <= ctl2_r; ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r; ctl6_r <= ctl5_r; ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1_r <= in_cell_value; col1_r <= in_cell_col; row1_r <= in_cell_row;
      qw1_r <= in_quat_w; qx1_r <= in_quat_x; qy1_r <= in_quat_y; qz1_r <= in_quat_z;
      px1_r <= in_pos_x; py1_r <= in_pos_y;

      val2_r <= val1_r; col2_r <= col1_r; row2_r <= row1_r;
      px2_r <= px1_r; py2_r <= py1_r;
      pcx2_r <= 41'({col1_r, 1'b1}) * 41'(cfg.local_cell_size);
      pcy2_r <= 41'({row1_r, 1'b1}) * 41'(cfg.local_cell_size);
      ww2_r <= qw1_r * qw1_r; xx2_r <= qx1_r * qx1_r;
      yy2_r <= qy1_r * qy1_r; zz2_r <= qz1_r * qz1_r;
      xy2_r <= qx1_r * qy1_r; wz2_r <= qw1_r * qz1_r;

      val3_r <= val2_r; col3_r <= col2_r; row3_r <= row2_r;
      px3_r <= px2_r; py3_r <= py2_r;
      vx3_r <= ogf_pkg::sat32(42'($signed({1'b0, pcx2_r[40:1]})) + 42'(cfg.local_origin_x));
      vy3_r <= ogf_pkg::sat32(42'($signed({1'b0, pcy2_r[40:1]})) + 42'(cfg.local_origin_y));
      m00_3_r <= 34'(ww2_r) + 34'(xx2_r) - 34'(yy2_r) - 34'(zz2_r);
      m01_3_r <= (34'(xy2_r) + 34'(wz2_r)) <<< 1;
      m10_3_r <= (34'(xy2_r) - 34'(wz2_r)) <<< 1;
      m11_3_r <= 34'(ww2_r) - 34'(xx2_r) + 34'(yy2_r) - 34'(zz2_r);

      val4_r <= val3_r; col4_r <= col3_r; row4_r <= row3_r;
      px4_r <= px3_r; py4_r <= py3_r;
      p00_4_r <= 66'(m00_3_r) * 66'(vx3_r);
      p01_4_r <= 66'(m01_3_r) * 66'(vy3_r);
      p10_4_r <= 66'(m10_3_r) * 66'(vx3_r);
      p11_4_r <= 66'(m11_3_r) * 66'(vy3_r);

      val5_r <= val4_r; col5_r <= col4_r; row5_r <= row4_r;
      ex5_r <= ogf_pkg::sat32(42'(rx_nxt) - 42'(px4_r));
      ey5_r <= ogf_pkg::sat32(42'(ry_nxt) - 42'(py4_r));

      val6_r <= val5_r; col6_r <= col5_r; row6_r <= row5_r;
      dx6_r <= ogf_pkg::sat32(42'(ex5_r) - 42'(cfg.global_min_x));
      dy6_r <= ogf_pkg::sat32(42'(ey5_r) - 42'(cfg.global_min_y));

      val7_r <= val6_r; col7_r <= col6_r; row7_r <= row6_r;
      bpx7_r <= 65'(dx6_r) * 65'($signed({1'b0, cfg.global_inv_cell}));
      bpy7_r <= 65'(dy6_r) * 65'($signed({1'b0, cfg.global_inv_cell}));
    end
  end

  assign ctl_o = ctl7_r;
  assign val_o = val7_r;
  assign col_o = col7_r;
  assign row_o = row7_r;
  assign bpx_o = bpx7_r;
  assign bpy_o = bpy7_r;

endmodule

@@ sv/ogf_grid.sv @@
module ogf_grid #(
  parameter int GRID_W = ogf_pkg::GRID_W_DEF,
  parameter int GRID_H = ogf_pkg::GRID_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               out_stall,
  input  ogf_pkg::ctl_t      ctl_i,
  input  logic signed [7:0]  val_i,
  input  logic [7:0]         col_i,
  input  logic [7:0]         row_i,
  input  logic signed [64:0] bpx_i,
  input  logic signed [64:0] bpy_i,
  output logic               en,
  output logic               clearing,
  output logic               out_valid,
  output logic signed [7:0]  out_read_value,
  output logic               out_wrote,
  output logic [7:0]         out_bin_x,
  output logic [7:0]         out_bin_y
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int BXW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int BYW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [7:0] mem_r [DEPTH];
  logic signed [7:0] rd_r;
  logic [AW-1:0] clr_cnt_r;
  logic clearing_r, out_valid_r, wrote_r, is_read_r;
  logic [BXW-1:0] bx_r, bx_nxt;
  logic [BYW-1:0] by_r, by_nxt;
  logic signed [32:0] fx, fy;
  logic [AW-1:0] addr, waddr;
  logic we;
  logic signed [7:0] wdata;

  assign en = !out_valid_r || !out_stall;

  always_comb begin
    fx = bpx_i[64:32];
    fy = bpy_i[64:32];
    bx_nxt = '0;
    by_nxt = '0;
    if (ctl_i.rd) begin
      bx_nxt = (33'(col_i) > 33'(GRID_W - 1)) ? BXW'(GRID_W - 1) : BXW'(col_i);
      by_nxt = (33'(row_i) > 33'(GRID_H - 1)) ? BYW'(GRID_H - 1) : BYW'(row_i);
    end else if (ctl_i.wr) begin
      if (fx < 33'sd0) begin
        bx_nxt = '0;
      end else if (fx > 33'(GRID_W - 1)) begin
        bx_nxt = BXW'(GRID_W - 1);
      end else begin
        bx_nxt = BXW'(fx);
      end
      if (fy < 33'sd0) begin
        by_nxt = '0;
      end else if (fy > 33'(GRID_H - 1)) begin
        by_nxt = BYW'(GRID_H - 1);
      end else begin
        by_nxt = BYW'(fy);
      end
    end
    addr  = AW'(by_nxt) * AW'(GRID_W) + AW'(bx_nxt);
    we    = clearing_r || (en && ctl_i.vld && ctl_i.wr);
    waddr = clearing_r ? clr_cnt_r : addr;
    wdata = clearing_r ? 8'sd0 : val_i;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (en) begin
      rd_r <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrote_r   <= ctl_i.wr;
      is_read_r <= ctl_i.rd;
      bx_r      <= bx_nxt;
      by_r      <= by_nxt;
    end
  end

  assign clearing       = clearing_r;
  assign out_valid      = out_valid_r;
  assign out_read_value = is_read_r ? rd_r : 8'sd0;
  assign out_wrote      = wrote_r;
  assign out_bin_x      = 8'(bx_r);
  assign out_bin_y      = 8'(by_r);

endmodule

@@ sv/occupancy_grid_fusion.sv @@
// Occupancy grid fusion.
// Input channel (in_valid/in_stall): one word per item. in_command selects a fuse
// of one local cell (value, column, row, pose) or a read of one global cell.
// Result channel (out_valid/out_stall): exactly one word per item, in order.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register; write
// only while no item is in flight.
// Throughput: one item a cycle while neither out_stall nor the clearing pass
// holds the input, set by a seven-stage arithmetic pipe feeding a grid memory
// with one write port and one read port in the output stage.
// Reset: control and configuration registers return to defaults and a clearing
// pass writes zero to every grid cell, one cell a cycle; in_stall is high
// throughout.
// Stall: while out_stall holds a pending word, the whole pipe holds and in_stall
// rises; nothing is lost or repeated.
module occupancy_grid_fusion #(
  parameter int GRID_W = ogf_pkg::GRID_W_DEF,
  parameter int GRID_H = ogf_pkg::GRID_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [7:0]  in_cell_value,
  input  logic [7:0]         in_cell_col,
  input  logic [7:0]         in_cell_row,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_read_value,
  output logic               out_wrote,
  output logic [7:0]         out_bin_x,
  output logic [7:0]         out_bin_y
);

  ogf_pkg::cfg_t cfg_r;
  ogf_pkg::ctl_t ctl;
  logic en, clearing, in_take;
  logic signed [7:0] val;
  logic [7:0] col, row;
  logic signed [64:0] bpx, bpy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.global_min_x    <= '0;
      cfg_r.global_min_y    <= '0;
      cfg_r.global_inv_cell <= ogf_pkg::INV_CELL_RST;
      cfg_r.local_origin_x  <= '0;
      cfg_r.local_origin_y  <= '0;
      cfg_r.local_cell_size <= ogf_pkg::CELL_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ogf_pkg::REG_GLOBAL_MIN_X:    cfg_r.global_min_x    <= cfg_wdata;
        ogf_pkg::REG_GLOBAL_MIN_Y:    cfg_r.global_min_y    <= cfg_wdata;
        ogf_pkg::REG_GLOBAL_INV_CELL: cfg_r.global_inv_cell <= cfg_wdata;
        ogf_pkg::REG_LOCAL_ORIGIN_X:  cfg_r.local_origin_x  <= cfg_wdata;
        ogf_pkg::REG_LOCAL_ORIGIN_Y:  cfg_r.local_origin_y  <= cfg_wdata;
        ogf_pkg::REG_LOCAL_CELL_SIZE: cfg_r.local_cell_size <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = clearing || !en;
  assign in_take  = in_valid && !in_stall;

  ogf_xform u_xform (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .cfg           (cfg_r),
    .in_take       (in_take),
    .in_command    (in_command),
    .in_cell_value (in_cell_value),
    .in_cell_col   (in_cell_col),
    .in_cell_row   (in_cell_row),
    .in_quat_w     (in_quat_w),
    .in_quat_x     (in_quat_x),
    .in_quat_y     (in_quat_y),
    .in_quat_z     (in_quat_z),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .ctl_o         (ctl),
    .val_o         (val),
    .col_o         (col),
    .row_o         (row),
    .bpx_o         (bpx),
    .bpy_o         (bpy)
  );

  ogf_grid #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_grid (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_stall      (out_stall),
    .ctl_i          (ctl),
    .val_i          (val),
    .col_i          (col),
    .row_i          (row),
    .bpx_i          (bpx),
    .bpy_i          (bpy),
    .en             (en),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_wrote      (out_wrote),
    .out_bin_x      (out_bin_x),
    .out_bin_y      (out_bin_y)
  );

`include "occupancy_grid_fusion_assert.svh"

  `OGF_ASSERT_IMPL(a_clear_blocks_input, clearing, in_stall)
  `OGF_ASSERT_IMPL(a_clear_no_output, clearing, !out_valid)
  `OGF_ASSERT_IMPL(a_fuse_reads_zero, out_valid && out_wrote, out_read_value == 8'sd0)

endmodule

@@ tb/sv/tb.sv @@
module tb;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic               command;
    logic signed [7:0]  value;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } grid_word_t;

  typedef struct {
    logic signed [7:0] read_value;
    logic              wrote;
    logic [7:0]        bin_x;
    logic [7:0]        bin_y;
  } cell_result_t;

  class grid_scoreboard;
    logic signed [7:0]  store [65536];
    logic signed [31:0] min_x, min_y, origin_x, origin_y;
    logic        [31:0] inv_cell, cell_size;
    cell_result_t       pending [$];
    logic [15:0]        touched [$];
    int                 mismatches;
    int                 checked;
    int                 fuses_written;
    int                 reads_done;

    function new();
      foreach (store[i]) store[i] = '0;
      min_x = '0;
      min_y = '0;
      inv_cell = ogf_pkg::INV_CELL_RST;
      origin_x = '0;
      origin_y = '0;
      cell_size = ogf_pkg::CELL_SIZE_RST;
      mismatches = 0;
      checked = 0;
      fuses_written = 0;
      reads_done = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        ogf_pkg::REG_GLOBAL_MIN_X:    min_x = data;
        ogf_pkg::REG_GLOBAL_MIN_Y:    min_y = data;
        ogf_pkg::REG_GLOBAL_INV_CELL: inv_cell = data;
        ogf_pkg::REG_LOCAL_ORIGIN_X:  origin_x = data;
        ogf_pkg::REG_LOCAL_ORIGIN_Y:  origin_y = data;
        ogf_pkg::REG_LOCAL_CELL_SIZE: cell_size = data;
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint to_bin(longint d);
      longint b;
      b = (d * longint'(inv_cell)) >>> 32;
      if (b > 255) b = 255;
      if (b < 0) b = 0;
      return b;
    endfunction

    function longint rot_term(longint m, longint v);
      logic signed [79:0] wm, wv, prod;
      wm = m;
      wv = v;
      prod = (wm * wv) >>> 30;
      return longint'(prod);
    endfunction

    function void note_input(grid_word_t w);
      cell_result_t r;
      longint vx, vy, qw, qx, qy, qz, m00, m01, m10, m11, rx, ry, dx, dy, bx, by;
      r = '{default: '0};
      if (w.command == ogf_pkg::CMD_READ) begin
        r.read_value = store[{w.row, w.col}];
        r.bin_x = w.col;
        r.bin_y = w.row;
        reads_done++;
      end else if (w.value == ogf_pkg::VAL_OBSTACLE || w.value > 0) begin
        vx = ((2 * longint'(w.col) + 1) * longint'(cell_size)) >>> 1;
        vy = ((2 * longint'(w.row) + 1) * longint'(cell_size)) >>> 1;
        vx = clip32(vx + longint'(origin_x));
        vy = clip32(vy + longint'(origin_y));
        qw = w.qw;
        qx = w.qx;
        qy = w.qy;
        qz = w.qz;
        m00 = qw * qw + qx * qx - qy * qy - qz * qz;
        m01 = 2 * (qx * qy + qw * qz);
        m10 = 2 * (qx * qy - qw * qz);
        m11 = qw * qw - qx * qx + qy * qy - qz * qz;
        rx = rot_term(m00, vx) + rot_term(m01, vy);
        ry = rot_term(m10, vx) + rot_term(m11, vy);
        dx = clip32(clip32(rx - longint'(w.px)) - longint'(min_x));
        dy = clip32(clip32(ry - longint'(w.py)) - longint'(min_y));
        bx = to_bin(dx);
        by = to_bin(dy);
        r.wrote = 1'b1;
        r.bin_x = bx[7:0];
        r.bin_y = by[7:0];
        store[{r.bin_y, r.bin_x}] = w.value;
        touched.push_back({r.bin_y, r.bin_x});
        if (touched.size() > 32) void'(touched.pop_front());
        fuses_written++;
      end
      pending.push_back(r);
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %0d wrote %0b bin %0d,%0d",
                   got.read_value, got.wrote, got.bin_x, got.bin_y);
        return;
      end
      exp_r = pending.pop_front();
      if (got.read_value !== exp_r.read_value || got.wrote !== exp_r.wrote ||
          got.bin_x !== exp_r.bin_x || got.bin_y !== exp_r.bin_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: expected value %0d wrote %0b bin %0d,%0d, got %0d %0b %0d,%0d",
                   checked, exp_r.read_value, exp_r.wrote, exp_r.bin_x, exp_r.bin_y,
                   got.read_value, got.wrote, got.bin_x, got.bin_y);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = 1'b0;
  logic signed [7:0]  in_cell_value = '0;
  logic [7:0]         in_cell_col = '0;
  logic [7:0]         in_cell_row = '0;
  logic signed [15:0] in_quat_w = '0;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [7:0]  out_read_value;
  logic               out_wrote;
  logic [7:0]         out_bin_x;
  logic [7:0]         out_bin_y;

  grid_scoreboard sb = new();
  int  cycles = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  sent = 0;

  occupancy_grid_fusion uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    cell_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.read_value = out_read_value;
      got.wrote = out_wrote;
      got.bin_x = out_bin_x;
      got.bin_y = out_bin_y;
      sb.check_result(got);
    end
  end

  task automatic send_word(grid_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= w.command;
    in_cell_value <= w.value;
    in_cell_col <= w.col;
    in_cell_row <= w.row;
    in_quat_w <= w.qw;
    in_quat_x <= w.qx;
    in_quat_y <= w.qy;
    in_quat_z <= w.qz;
    in_pos_x <= w.px;
    in_pos_y <= w.py;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] gx, logic [31:0] gy, logic [31:0] inv,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] cs);
    logic [31:0] vals [6];
    vals = '{gx, gy, inv, ox, oy, cs};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic grid_word_t fuse_word(logic signed [7:0] v, logic [7:0] c, logic [7:0] r,
                                           logic signed [15:0] qw, logic signed [15:0] qz,
                                           logic signed [31:0] px, logic signed [31:0] py);
    grid_word_t w;
    w = '{ogf_pkg::CMD_FUSE, v, c, r, qw, 16'sd0, 16'sd0, qz, px, py};
    return w;
  endfunction

  function automatic grid_word_t read_word(logic [7:0] c, logic [7:0] r);
    grid_word_t w;
    w = '{ogf_pkg::CMD_READ, 8'($urandom), c, r, 16'($urandom), 16'($urandom),
          16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom)};
    return w;
  endfunction

  function automatic grid_word_t random_word();
    grid_word_t w;
    real ang;
    logic [15:0] pick;
    w.command = ($urandom_range(3) == 0) ? ogf_pkg::CMD_READ : ogf_pkg::CMD_FUSE;
    if ($urandom_range(99) < 85)
      w.value = ($urandom_range(3) == 0) ? ogf_pkg::VAL_OBSTACLE : 8'($urandom_range(127, 1));
    else
      w.value = 8'($urandom);
    w.col = 8'($urandom);
    w.row = 8'($urandom);
    if ($urandom_range(1)) begin
      ang = $urandom_range(6283) / 1000.0;
      w.qw = 16'(int'($cos(ang / 2.0) * 32767.0));
      w.qz = 16'(int'($sin(ang / 2.0) * 32767.0));
      w.qx = '0;
      w.qy = '0;
    end else begin
      w.qw = 16'($urandom);
      w.qx = 16'($urandom);
      w.qy = 16'($urandom);
      w.qz = 16'($urandom);
    end
    if ($urandom_range(99) < 80) begin
      w.px = 32'($urandom_range(200 << 16)) - (100 << 16);
      w.py = 32'($urandom_range(200 << 16)) - (100 << 16);
    end else begin
      w.px = $urandom;
      w.py = $urandom;
    end
    if (w.command == ogf_pkg::CMD_READ && sb.touched.size() > 0 && $urandom_range(1)) begin
      pick = sb.touched[$urandom_range(sb.touched.size() - 1)];
      w.col = pick[7:0];
      w.row = pick[15:8];
    end
    return w;
  endfunction

  initial begin
    int modes_idle [4];
    int modes_stall [4];
    modes_idle = '{0, 66, 0, 7};
    modes_stall = '{0, 0, 66, 7};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall);

    // directed: defaults, identity and extreme poses, ignored values, reads back
    send_word(read_word(8'd0, 8'd0));
    send_word(read_word(8'd255, 8'd255));
    send_word(fuse_word(ogf_pkg::VAL_OBSTACLE, 8'd0, 8'd0, 16'sd32767, 16'sd0, 32'sd0,
                        32'sd0));
    send_word(fuse_word(8'sd1, 8'd255, 8'd255, 16'sd32767, 16'sd0, 32'sd0, 32'sd0));
    send_word(fuse_word(8'sd127, 8'd10, 8'd20, 16'sd32767, 16'sd0, -32'sd655360, 32'sd0));
    send_word(fuse_word(8'sd0, 8'd5, 8'd5, 16'sd32767, 16'sd0, 32'sd0, 32'sd0));
    send_word(fuse_word(-8'sd128, 8'd5, 8'd5, 16'sd32767, 16'sd0, 32'sd0, 32'sd0));
    send_word(fuse_word(-8'sd2, 8'd5, 8'd5, 16'sd32767, 16'sd0, 32'sd0, 32'sd0));
    send_word(fuse_word(8'sd3, 8'd100, 8'd100, -16'sd32768, 16'sd0, 32'sh7fffffff,
                        32'sh80000000));
    send_word(fuse_word(8'sd4, 8'd100, 8'd100, 16'sd0, -16'sd32768, 32'sh80000000,
                        32'sh7fffffff));
    send_word(fuse_word(8'sd5, 8'd200, 8'd50, 16'sd23170, 16'sd23170, 32'sd0, 32'sd0));
    send_word('{ogf_pkg::CMD_FUSE, 8'sd6, 8'd255, 8'd255, -16'sd32768, -16'sd32768,
                -16'sd32768, -16'sd32768, 32'sh80000000, 32'sh80000000});
    send_word('{ogf_pkg::CMD_FUSE, 8'sd7, 8'd255, 8'd0, 16'sd32767, 16'sd32767, 16'sd32767,
                16'sd32767, 32'sh7fffffff, 32'sh7fffffff});
    send_word(read_word(8'd0, 8'd0));
    send_word(read_word(8'd255, 8'd255));
    send_word(read_word(8'd5, 8'd5));
    send_word(read_word(8'd25, 8'd5));
    send_word(read_word(8'd0, 8'd255));
    send_word(read_word(8'd255, 8'd0));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_regs(-32'sd3276800, -32'sd3276800, 32'd131072, -32'sd196608, 32'sd131072,
                      32'd3277);
        1: write_regs(32'h80000000, 32'h80000000, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                      32'hffffffff);
        2: write_regs(32'h7fffffff, 32'h7fffffff, 32'd1, 32'd0, 32'd0, 32'd1);
        default: write_regs(-32'sd8388608, -32'sd8388608, 32'd65536, 32'd0, 32'd0,
                            32'd13107);
      endcase
      for (int m = 0; m < 4; m++) begin
        idle_pct = modes_idle[m];
        stall_pct = modes_stall[m];
        if (p == 0 && m == 0) hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
          send_word(random_word());
          if (p == 3 && m == 1 && k == 20) drain();
        end
      end
    end

    drain();
    idle_pct = 0;
    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("sent %0d words: %0d fuses written, %0d reads, %0d results checked",
             sent, sb.fuses_written, sb.reads_done, sb.checked);
    $display("five register settings incl. extremes, four idle/stall mixes, one long hold-off");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
